FILE: sv/adjacency_list_store_assert.svh
// assertion macros for the adjacency list store
`ifndef ADJACENCY_LIST_STORE_ASSERT_SVH
`define ADJACENCY_LIST_STORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define ALS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("adjacency list store check failed");
`define ALS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("adjacency list store check failed");
`else
`define ALS_ASSERT_IMPL(label, ante, cons)
`define ALS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: sv/als_pkg.sv
// types and constants shared by the adjacency list store
package als_pkg;

    localparam int VTX_W            = 6;
    localparam int WGT_W            = 16;
    localparam int NV_W             = 7;
    localparam int DEF_MAX_VERTICES = 64;
    localparam int DEF_MAX_DEGREE   = 16;
    localparam logic [NV_W-1:0] NV_RESET = NV_W'(64);

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_ADD   = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_LIST  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        action_t                   action;
        logic [VTX_W-1:0]          src_vertex;
        logic [VTX_W-1:0]          dst_vertex;
        logic signed [WGT_W-1:0]   edge_weight;
    } als_cmd_t;

    typedef struct packed {
        status_t                   status;
        logic                      found;
        logic                      neighbor_valid;
        logic [VTX_W-1:0]          neighbor_id;
        logic signed [WGT_W-1:0]   neighbor_weight;
        logic                      last;
    } als_res_t;

    typedef logic [NV_W-1:0] als_cfg_t;

endpackage

FILE: sv/als_chan_if.sv
// valid/ready channel carrying one item
interface als_chan_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: sv/als_ram.sv
// generic single-port-write ram with registered read
module als_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/adjacency_list_store.sv
// adjacency list store top level
//
// cmd carries one item: action, source, destination, weight. res carries
// results; cfg writes num_vertices (always ready, write only while idle).
// cmd.ready is high only while no item is in work; the output register lets
// the block take and work on the next item while a result still waits on res.
// steps from an accepted item to its first result on res:
//   add edge, range or full errors: degree read, then the result (S_RESP)
//   is-adjacent: degree read, then one stored entry compared per cycle
//   get neighbors: degree read, then one entry per cycle while res is taken
//   clear: the degree sweep (S_CLR), then the result
// scans and lists run at one edge ram read per cycle unless res stalls a list.
// after reset the degree ram is swept to zero, min(MAX_VERTICES, 64) entries,
// with cmd.ready low; cfg writes are taken during the sweep.
// a stall on res holds the result register and freezes the neighbor walk.
`include "adjacency_list_store_assert.svh"

module adjacency_list_store
    import als_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_DEGREE   = DEF_MAX_DEGREE
) (
    input  logic       clk,
    input  logic       rst_n,
    als_chan_if.sink   cmd,
    als_chan_if.source res,
    als_chan_if.sink   cfg
);

    localparam int VA         = $clog2(MAX_VERTICES);
    localparam int EDGE_DEPTH = MAX_VERTICES * MAX_DEGREE;
    localparam int EA         = $clog2(EDGE_DEPTH);
    localparam int DW         = $clog2(MAX_DEGREE + 1);
    localparam int SW         = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int CLR_N      = (MAX_VERTICES < (2 ** VTX_W)) ? MAX_VERTICES : (2 ** VTX_W);
    localparam int EW         = VTX_W + WGT_W;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_CLR  = 6'b000010,
        S_DEG  = 6'b000100,
        S_SCAN = 6'b001000,
        S_LIST = 6'b010000,
        S_RESP = 6'b100000
    } state_t;

    state_t                  state_reg, state_next;
    logic [VA-1:0]           clr_idx_reg, clr_idx_next;
    logic                    clr_reply_reg, clr_reply_next;
    logic [NV_W-1:0]         num_vertices_reg;
    logic                    out_valid_reg, out_valid_next;
    als_res_t                out_data_reg, out_data_next;

    action_t                 action_reg, action_next;
    logic [VTX_W-1:0]        src_reg, src_next;
    logic [VTX_W-1:0]        dst_reg, dst_next;
    logic signed [WGT_W-1:0] weight_reg, weight_next;
    logic [DW-1:0]           deg_reg, deg_next;
    logic [SW-1:0]           slot_reg, slot_next;
    logic                    hit_reg, hit_next;
    status_t                 resp_status_reg, resp_status_next;
    logic                    resp_found_reg, resp_found_next;

    logic                    deg_we;
    logic [VA-1:0]           deg_waddr;
    logic [DW-1:0]           deg_wdata;
    logic [VA-1:0]           deg_raddr;
    logic [DW-1:0]           deg_rdata;

    logic                    edge_we;
    logic [EA-1:0]           edge_waddr;
    logic [EW-1:0]           edge_wdata;
    logic [EA-1:0]           edge_raddr;
    logic [EW-1:0]           edge_rdata;

    logic                    cmd_fire;
    logic                    can_load;
    logic [VA-1:0]           vtx_idx;
    logic [EA-1:0]           base_addr;
    logic [SW-1:0]           rd_slot;
    logic                    src_ok;
    logic                    dst_ok;
    logic                    slot_last;
    logic                    scan_hit;
    logic [VTX_W-1:0]        entry_id;
    logic signed [WGT_W-1:0] entry_weight;

    als_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_VERTICES)
    ) u_deg_ram (
        .clk   (clk),
        .we    (deg_we),
        .waddr (deg_waddr),
        .wdata (deg_wdata),
        .raddr (deg_raddr),
        .rdata (deg_rdata)
    );

    als_ram #(
        .WIDTH (EW),
        .DEPTH (EDGE_DEPTH)
    ) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .raddr (edge_raddr),
        .rdata (edge_rdata)
    );

    assign cmd_fire   = cmd.valid && cmd.ready;
    assign cmd.ready  = (state_reg == S_IDLE);
    assign cfg.ready  = 1'b1;
    assign res.valid  = out_valid_reg;
    assign res.data   = out_data_reg;
    assign can_load   = !out_valid_reg || res.ready;

    assign vtx_idx    = VA'(src_reg);
    assign base_addr  = EA'(EA'(vtx_idx) * EA'(MAX_DEGREE));
    assign src_ok     = (NV_W'(src_reg) < num_vertices_reg) && (32'(src_reg) < MAX_VERTICES);
    assign dst_ok     = (NV_W'(dst_reg) < num_vertices_reg) && (32'(dst_reg) < MAX_VERTICES);
    assign slot_last  = (DW'(slot_reg) + DW'(1)) == deg_reg;
    assign entry_id     = edge_rdata[WGT_W +: VTX_W];
    assign entry_weight = edge_rdata[WGT_W-1:0];
    assign scan_hit   = hit_reg || (entry_id == dst_reg);

    assign deg_raddr  = VA'(cmd.data.src_vertex);
    assign edge_waddr = EA'(base_addr + EA'(deg_rdata));
    assign edge_wdata = {dst_reg, weight_reg};
    assign edge_raddr = EA'(base_addr + EA'(rd_slot));

    always_comb
    begin
        state_next       = state_reg;
        clr_idx_next     = clr_idx_reg;
        clr_reply_next   = clr_reply_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;
        action_next      = action_reg;
        src_next         = src_reg;
        dst_next         = dst_reg;
        weight_next      = weight_reg;
        deg_next         = deg_reg;
        slot_next        = slot_reg;
        hit_next         = hit_reg;
        resp_status_next = resp_status_reg;
        resp_found_next  = resp_found_reg;
        deg_we           = 1'b0;
        deg_waddr        = vtx_idx;
        deg_wdata        = '0;
        edge_we          = 1'b0;
        rd_slot          = slot_reg;

        if (res.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLR:
            begin
                deg_we    = 1'b1;
                deg_waddr = clr_idx_reg;
                if (clr_idx_reg == VA'(CLR_N - 1))
                begin
                    clr_idx_next = '0;
                    if (clr_reply_reg)
                    begin
                        resp_status_next = STAT_OK;
                        resp_found_next  = 1'b0;
                        state_next       = S_RESP;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + VA'(1);
                end
            end
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    action_next = cmd.data.action;
                    src_next    = cmd.data.src_vertex;
                    dst_next    = cmd.data.dst_vertex;
                    weight_next = cmd.data.edge_weight;
                    if (cmd.data.action == ACT_CLEAR)
                    begin
                        clr_reply_next = 1'b1;
                        state_next     = S_CLR;
                    end
                    else
                    begin
                        state_next = S_DEG;
                    end
                end
            end
            S_DEG:
            begin
                deg_next         = deg_rdata;
                slot_next        = '0;
                hit_next         = 1'b0;
                rd_slot          = '0;
                resp_found_next  = 1'b0;
                resp_status_next = STAT_OK;
                state_next       = S_RESP;
                if (!src_ok || (action_reg != ACT_LIST && !dst_ok))
                begin
                    resp_status_next = STAT_RANGE;
                end
                else
                begin
                    case (action_reg)
                        ACT_ADD:
                        begin
                            if (deg_rdata == DW'(MAX_DEGREE))
                            begin
                                resp_status_next = STAT_FULL;
                            end
                            else
                            begin
                                edge_we   = 1'b1;
                                deg_we    = 1'b1;
                                deg_wdata = deg_rdata + DW'(1);
                            end
                        end
                        ACT_QUERY:
                        begin
                            if (deg_rdata != '0)
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        ACT_LIST:
                        begin
                            if (deg_rdata != '0)
                            begin
                                state_next = S_LIST;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                hit_next = scan_hit;
                if (slot_last)
                begin
                    resp_status_next = STAT_OK;
                    resp_found_next  = scan_hit;
                    state_next       = S_RESP;
                end
                else
                begin
                    slot_next = slot_reg + SW'(1);
                    rd_slot   = slot_reg + SW'(1);
                end
            end
            S_LIST:
            begin
                if (can_load)
                begin
                    out_valid_next                = 1'b1;
                    out_data_next.status          = STAT_OK;
                    out_data_next.found           = 1'b0;
                    out_data_next.neighbor_valid  = 1'b1;
                    out_data_next.neighbor_id     = entry_id;
                    out_data_next.neighbor_weight = entry_weight;
                    out_data_next.last            = slot_last;
                    rd_slot                       = slot_reg + SW'(1);
                    if (slot_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        slot_next = slot_reg + SW'(1);
                    end
                end
            end
            S_RESP:
            begin
                if (can_load)
                begin
                    out_valid_next                = 1'b1;
                    out_data_next.status          = resp_status_reg;
                    out_data_next.found           = resp_found_reg;
                    out_data_next.neighbor_valid  = 1'b0;
                    out_data_next.neighbor_id     = '0;
                    out_data_next.neighbor_weight = '0;
                    out_data_next.last            = 1'b1;
                    state_next                    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLR;
            clr_idx_reg      <= '0;
            clr_reply_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
            num_vertices_reg <= NV_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            clr_reply_reg <= clr_reply_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                num_vertices_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg    <= out_data_next;
        action_reg      <= action_next;
        src_reg         <= src_next;
        dst_reg         <= dst_next;
        weight_reg      <= weight_next;
        deg_reg         <= deg_next;
        slot_reg        <= slot_next;
        hit_reg         <= hit_next;
        resp_status_reg <= resp_status_next;
        resp_found_reg  <= resp_found_next;
    end

    // list and scan walks never pass the stored degree
    `ALS_ASSERT_IMPL(a_list_slot_bound, (state_reg == S_LIST) || (state_reg == S_SCAN), DW'(slot_reg) < deg_reg)
    // a list never grows past MAX_DEGREE entries
    `ALS_ASSERT_IMPL(a_degree_bound, deg_we, deg_wdata <= DW'(MAX_DEGREE))
    // an accepted item always leaves idle
    `ALS_ASSERT_NEXT(a_item_leaves_idle, cmd_fire, state_reg != S_IDLE)
    // results without an entry always end their item
    `ALS_ASSERT_IMPL(a_plain_result_last, res.valid && !res.data.neighbor_valid, res.data.last)

endmodule

FILE: dv/testbench.sv
// testbench for the adjacency list store: directed table, then random items checked per field
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import als_pkg::*;

    localparam int MAX_V       = DEF_MAX_VERTICES;
    localparam int MAX_D       = DEF_MAX_DEGREE;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 6;

    typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t               kind;
        als_cfg_t                nv;
        action_t                 action;
        logic [VTX_W-1:0]        src;
        logic [VTX_W-1:0]        dst;
        logic signed [WGT_W-1:0] weight;
        int                      copies;
        bit                      typed;
        status_t                 status;
        bit                      found;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n;

    als_chan_if #(.payload_t(als_cmd_t)) cmd_if ();
    als_chan_if #(.payload_t(als_res_t)) res_if ();
    als_chan_if #(.payload_t(als_cfg_t)) cfg_if ();

    adjacency_list_store dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .res   (res_if),
        .cfg   (cfg_if)
    );

    // shadow copy of the graph
    als_cfg_t         nv_shadow;
    int               adj_degree [MAX_V];
    logic [VTX_W-1:0] adj_dest   [MAX_V][MAX_D];
    logic [WGT_W-1:0] adj_weight [MAX_V][MAX_D];

    als_res_t expected_results[$];
    int       mismatches;
    int       cycle_count;
    int       burst_left;
    bit       hold_request;
    int       hold_left;
    int       pat_mode;
    int       pat_left;
    int       pat_tick;

    plan_row_t directed_plan [0:31] = '{
        '{ROW_CFG,  7'd64,  ACT_CLEAR, 6'd0,  6'd0,  16'sh0000, 1,  1'b0, STAT_OK,    1'b0},
        '{ROW_ITEM, 7'd0,   ACT_LIST,  6'd0,  6'd0,  16'sh0000, 1,  1'b1, STAT_OK,    1'b0},
        '{ROW_ITEM, 7'd0,   ACT_QUERY, 6'd0,  6'd63, 16'sh0000, 1,  1'b1, STAT_OK,    1'b0},
        '{ROW_ITEM, 7'd0,   ACT_ADD,   6'd0,  6'd63, 16'sh8000, 1,  1'b1, STAT_OK,    1'b0},
        '{ROW_ITEM, 7'd0,   ACT_ADD,   6'd0,  6'd0,  16'sh7fff, 1,  1'b1, STAT_OK,    1'b0},
        '{ROW_ITEM, 7'd0,   ACT_ADD,   6'd0,  6'd63, 16'shffff, 1,  1'b0, STAT_OK,    1'b0},
        '{ROW_ITEM, 7'd0,   ACT_QUERY, 6'd0,  6'd63, 16'sh0000, 1,  1'b1, STAT_OK,    1'b1},
        '{ROW_ITEM, 7'd0,   ACT_LIST,  6'd0,  6'd63, 16'sh0000, 1,  1'b0, STAT_OK,    1'b0},
        '{ROW_ITEM, 7'd0,   ACT_ADD,   6'd63, 6'd0,  16'sh5555, 1,  1'b1, STAT_OK,    1'b0},
        '{ROW_ITEM, 7'd0,   ACT_QUERY, 6'd63, 6'd0,  16'sh0000, 1,  1'b0, STAT_OK,    1'b0},
        '{ROW_ITEM, 7'd0,   ACT_LIST,  6'd63, 6'd0,  16'sh0000, 1,  1'b0, STAT_OK,    1'b0},
        '{ROW_ITEM, 7'd0,   ACT_ADD,   6'd5,  6'd42, 16'sh2aaa, 16, 1'b0, STAT_OK,    1'b0},
        '{ROW_ITEM, 7'd0,   ACT_ADD,   6'd5,  6'd42, 16'sh1111, 1,  1'b1, STAT_FULL,  1'b0},
        '{ROW_ITEM, 7'd0,   ACT_LIST,  6'd5,  6'd0,  16'sh0000, 1,  1'b0, STAT_OK,    1'b0},
        '{ROW_ITEM, 7'd0,   ACT_QUERY, 6'd5,  6'd21, 16'sh0000, 1,  1'b1, STAT_OK,    1'b0},
        '{ROW_ITEM, 7'd0,   ACT_CLEAR, 6'd63, 6'd63, 16'shffff, 1,  1'b1, STAT_OK,    1'b0},
        '{ROW_ITEM, 7'd0,   ACT_LIST,  6'd5,  6'd0,  16'sh0000, 1,  1'b1, STAT_OK,    1'b0},
        '{ROW_ITEM, 7'd0,   ACT_QUERY, 6'd0,  6'd63, 16'sh0000, 1,  1'b1, STAT_OK,    1'b0},
        '{ROW_CFG,  7'd1,   ACT_CLEAR, 6'd0,  6'd0,  16'sh0000, 1,  1'b0, STAT_OK,    1'b0},
        '{ROW_ITEM, 7'd0,   ACT_ADD,   6'd0,  6'd1,  16'sh0000, 1,  1'b1, STAT_RANGE, 1'b0},
        '{ROW_ITEM, 7'd0,   ACT_ADD,   6'd1,  6'd0,  16'sh0000, 1,  1'b1, STAT_RANGE, 1'b0},
        '{ROW_ITEM, 7'd0,   ACT_QUERY, 6'd0,  6'd63, 16'sh0000, 1,  1'b1, STAT_RANGE, 1'b0},
        '{ROW_ITEM, 7'd0,   ACT_LIST,  6'd1,  6'd0,  16'sh0000, 1,  1'b1, STAT_RANGE, 1'b0},
        '{ROW_ITEM, 7'd0,   ACT_ADD,   6'd0,  6'd0,  16'sh1234, 1,  1'b1, STAT_OK,    1'b0},
        '{ROW_ITEM, 7'd0,   ACT_LIST,  6'd0,  6'd63, 16'sh0000, 1,  1'b0, STAT_OK,    1'b0},
        '{ROW_CFG,  7'd0,   ACT_CLEAR, 6'd0,  6'd0,  16'sh0000, 1,  1'b0, STAT_OK,    1'b0},
        '{ROW_ITEM, 7'd0,   ACT_LIST,  6'd0,  6'd0,  16'sh0000, 1,  1'b1, STAT_RANGE, 1'b0},
        '{ROW_ITEM, 7'd0,   ACT_CLEAR, 6'd0,  6'd0,  16'sh0000, 1,  1'b1, STAT_OK,    1'b0},
        '{ROW_CFG,  7'd127, ACT_CLEAR, 6'd0,  6'd0,  16'sh0000, 1,  1'b0, STAT_OK,    1'b0},
        '{ROW_ITEM, 7'd0,   ACT_ADD,   6'd63, 6'd63, 16'sh8001, 1,  1'b1, STAT_OK,    1'b0},
        '{ROW_ITEM, 7'd0,   ACT_LIST,  6'd63, 6'd0,  16'sh0000, 1,  1'b0, STAT_OK,    1'b0},
        '{ROW_ITEM, 7'd0,   ACT_QUERY, 6'd63, 6'd63, 16'sh0000, 1,  1'b1, STAT_OK,    1'b1}
    };

    int phase_nv  [PHASES] = '{64, 1, 127, 0, 9, 64};
    int phase_len [PHASES] = '{95, 25, 70, 12, 60, 65};

    always #10 clk = ~clk;

    function automatic void graph_predict(input als_cmd_t c, output als_res_t outs[$]);
        als_res_t r;
        int       lim;
        int       deg;
        int       s;
        int       d;
        outs.delete();
        r = '0;
        r.status = STAT_OK;
        r.last = 1'b1;
        lim = (nv_shadow > MAX_V) ? MAX_V : int'(nv_shadow);
        s = c.src_vertex;
        d = c.dst_vertex;
        if (c.action == ACT_CLEAR) begin
            foreach (adj_degree[i])
                adj_degree[i] = 0;
            outs = {outs, r};
            return;
        end
        if (s >= lim || (c.action != ACT_LIST && d >= lim)) begin
            r.status = STAT_RANGE;
            outs = {outs, r};
            return;
        end
        deg = adj_degree[s];
        case (c.action)
            ACT_ADD:
            begin
                if (deg >= MAX_D) begin
                    r.status = STAT_FULL;
                end
                else begin
                    adj_dest[s][deg] = c.dst_vertex;
                    adj_weight[s][deg] = c.edge_weight;
                    adj_degree[s] = deg + 1;
                end
                outs = {outs, r};
            end
            ACT_QUERY:
            begin
                for (int i = 0; i < deg; i++)
                    if (adj_dest[s][i] == c.dst_vertex)
                        r.found = 1'b1;
                outs = {outs, r};
            end
            default:
            begin
                if (deg == 0)
                    outs = {outs, r};
                for (int i = 0; i < deg; i++) begin
                    r.neighbor_valid = 1'b1;
                    r.neighbor_id = adj_dest[s][i];
                    r.neighbor_weight = adj_weight[s][i];
                    r.last = (i == deg - 1);
                    outs = {outs, r};
                end
            end
        endcase
    endfunction

    function automatic als_cmd_t random_item(input int span, input int hot);
        als_cmd_t c;
        int       roll;
        int       near;
        roll = $urandom_range(0, 99);
        if (roll < 2)
            c.action = ACT_CLEAR;
        else if (roll < 55)
            c.action = ACT_ADD;
        else if (roll < 77)
            c.action = ACT_QUERY;
        else
            c.action = ACT_LIST;
        roll = $urandom_range(0, 9);
        if (span == 0 || roll == 0)
            c.src_vertex = VTX_W'($urandom_range(0, 63));
        else if (roll < 7)
            c.src_vertex = VTX_W'((hot + $urandom_range(0, 1)) % span);
        else
            c.src_vertex = VTX_W'($urandom_range(0, span - 1));
        near = (span < 4) ? span : 4;
        roll = $urandom_range(0, 9);
        if (span == 0 || roll == 0)
            c.dst_vertex = VTX_W'($urandom_range(0, 63));
        else if (roll < 5)
            c.dst_vertex = VTX_W'($urandom_range(0, near - 1));
        else
            c.dst_vertex = VTX_W'($urandom_range(0, span - 1));
        roll = $urandom_range(0, 19);
        if (roll == 0)
            c.edge_weight = 16'sh8000;
        else if (roll == 1)
            c.edge_weight = 16'sh7fff;
        else
            c.edge_weight = WGT_W'($urandom);
        return c;
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
            mismatches++;
        end
    endfunction

    task automatic issue_item(input als_cmd_t c, input bit typed, input status_t st,
                              input bit fnd);
        als_res_t outs[$];
        als_res_t r;
        cmd_if.valid <= 1'b1;
        cmd_if.data <= c;
        do
            @(posedge clk);
        while (cmd_if.ready !== 1'b1);
        graph_predict(c, outs);
        if (typed) begin
            r = '0;
            r.status = st;
            r.found = fnd;
            r.last = 1'b1;
            outs.delete();
            outs = {outs, r};
        end
        foreach (outs[i])
            expected_results = {expected_results, outs[i]};
        burst_left--;
        if (burst_left <= 0) begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
    endtask

    task automatic settle();
        cmd_if.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_num_vertices(input als_cfg_t v);
        cfg_if.valid <= 1'b1;
        cfg_if.data <= v;
        do
            @(posedge clk);
        while (cfg_if.ready !== 1'b1);
        cfg_if.valid <= 1'b0;
        nv_shadow = v;
    endtask

    // result side: random stall modes plus one long hold-off
    always @(posedge clk) begin
        pat_tick++;
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_if.ready <= 1'b0;
        end
        else begin
            if (pat_left <= 0) begin
                pat_mode = $urandom_range(0, 3);
                pat_left = $urandom_range(8, 60);
            end
            pat_left--;
            case (pat_mode)
                0: res_if.ready <= 1'b1;
                1: res_if.ready <= ($urandom_range(0, 3) != 0);
                2: res_if.ready <= ($urandom_range(0, 3) == 0);
                default: res_if.ready <= (pat_tick % 5 == 0);
            endcase
        end
    end

    always @(posedge clk) begin
        als_res_t want;
        if (rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result with nothing expected, got %h", $time, res_if.data);
                mismatches++;
            end
            else begin
                want = expected_results.pop_front();
                check_field("status", want.status, res_if.data.status);
                check_field("found", want.found, res_if.data.found);
                check_field("neighbor_valid", want.neighbor_valid,
                            res_if.data.neighbor_valid);
                check_field("neighbor_id", want.neighbor_id, res_if.data.neighbor_id);
                check_field("neighbor_weight", want.neighbor_weight,
                            res_if.data.neighbor_weight);
                check_field("last", want.last, res_if.data.last);
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial begin
        als_cmd_t c;
        int       span;
        int       hot;
        rst_n <= 1'b0;
        cmd_if.valid <= 1'b0;
        cmd_if.data <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.data <= '0;
        burst_left = 1;
        nv_shadow = NV_RESET;
        foreach (adj_degree[i])
            adj_degree[i] = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_plan[i]) begin
            if (directed_plan[i].kind == ROW_CFG) begin
                settle();
                set_num_vertices(directed_plan[i].nv);
            end
            else begin
                c.action = directed_plan[i].action;
                c.src_vertex = directed_plan[i].src;
                c.dst_vertex = directed_plan[i].dst;
                c.edge_weight = directed_plan[i].weight;
                for (int k = 0; k < directed_plan[i].copies; k++)
                    issue_item(c, directed_plan[i].typed, directed_plan[i].status,
                               directed_plan[i].found);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            settle();
            set_num_vertices(NV_W'(phase_nv[p]));
            span = (phase_nv[p] > MAX_V) ? MAX_V : phase_nv[p];
            hot = (span > 0) ? $urandom_range(0, span - 1) : 0;
            // fill the block while results are held back
            if (p == 0)
                hold_request = 1'b1;
            for (int n = 0; n < phase_len[p]; n++)
                issue_item(random_item(span, hot), 1'b0, STAT_OK, 1'b0);
        end

        settle();
        repeat (70) @(posedge clk);
        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/als_pkg.sv
sv/als_chan_if.sv
sv/als_ram.sv
sv/adjacency_list_store.sv
dv/testbench.sv
